// ----- hw/rtl/ipv4p_pkg.sv -----
package ipv4p_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned OctetW  = 8;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned UpperW  = 24;
  localparam int unsigned CountW  = 2;

  localparam logic [CharW-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CharW-1:0] CHAR_FIVE = 8'h35;
  localparam logic [CharW-1:0] CHAR_NINE = 8'h39;
  localparam logic [CharW-1:0] CHAR_DOT  = 8'h2E;

  // Largest tens-and-hundreds value that still allows a third digit.
  localparam logic [OctetW-1:0] OCTET_TENS_MAX = 8'd25;

  localparam logic [CountW-1:0] LAST_OCTET_IDX = 2'd3;

  localparam logic [7:0] NET_LOOPBACK   = 8'd127;
  localparam logic [7:0] NET_PRIV_A     = 8'd10;
  localparam logic [7:0] NET_PRIV_B_HI  = 8'd172;
  localparam logic [3:0] NET_PRIV_B_LO  = 4'd1;   // 172.16/12: upper nibble of octet two
  localparam logic [7:0] NET_PRIV_C_HI  = 8'd192;
  localparam logic [7:0] NET_PRIV_C_LO  = 8'd168;

  typedef struct packed {
    logic [UpperW-1:0] upper_octets;
    logic [OctetW-1:0] octet_value;
    logic [CountW-1:0] digit_count;
    logic [CountW-1:0] octet_index;
    logic              error_seen;
  } ipv4p_state_t;

  localparam ipv4p_state_t STATE_RESET = '0;

  typedef struct packed {
    logic             valid_res;
    logic [AddrW-1:0] address;
    logic             is_loopback;
    logic             is_private;
  } ipv4p_result_t;

endpackage

// ----- hw/rtl/ipv4p_in_if.sv -----
interface ipv4p_in_if;
  import ipv4p_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- hw/rtl/ipv4p_out_if.sv -----
interface ipv4p_out_if;
  import ipv4p_pkg::*;

  logic             valid;
  logic             ready;
  logic             valid_res;
  logic [AddrW-1:0] address;
  logic             is_loopback;
  logic             is_private;

  modport source (output valid, output valid_res, output address, output is_loopback,
                  output is_private, input ready);
  modport sink   (input valid, input valid_res, input address, input is_loopback,
                  input is_private, output ready);
endinterface

// ----- hw/rtl/ipv4_dotted_decimal_parser_core.sv -----
// Strict dotted-decimal IPv4 parser. Send the string one ASCII character per
// request on in_i, with last_char set on its final character; only that
// character produces a response on res_o, carrying the 32-bit address (first
// octet in bits 31:24), valid_res, and the loopback and private flags, all of
// which read zero for a malformed string. One character is taken every clock
// cycle while ready on in_i is high; responses are held in the output register.
// The input register frees as soon as its character has been folded into the
// parser state, so ready on in_i only drops while a finished response is
// still waiting in the output register and another last character is queued.
module ipv4_dotted_decimal_parser_core import ipv4p_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ipv4p_in_if.sink    in_i,
  ipv4p_out_if.source res_o
);

  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             out_valid_q;
  ipv4p_result_t    out_q;
  ipv4p_result_t    result;
  logic             advance;
  logic             step;

  // A character that yields no response can always move on; a last one needs
  // the output register to be free or emptying this cycle.
  assign advance    = !last_q || !out_valid_q || res_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      char_q <= in_i.char_code;
      last_q <= in_i.last_char;
    end
  end

  ipv4p_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_code_i (char_q),
    .last_char_i (last_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && last_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      out_q <= result;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.valid_res   = out_q.valid_res;
  assign res_o.address     = out_q.address;
  assign res_o.is_loopback = out_q.is_loopback;
  assign res_o.is_private  = out_q.is_private;

endmodule

// ----- hw/rtl/ipv4p_classify.sv -----
module ipv4p_classify import ipv4p_pkg::*; (
  input  logic             ok_i,
  input  logic [AddrW-1:0] address_i,
  output ipv4p_result_t    result_o
);

  logic [AddrW-1:0] addr;
  logic             net_a;
  logic             net_b;
  logic             net_c;

  assign addr  = ok_i ? address_i : '0;
  assign net_a = (addr[31:24] == NET_PRIV_A);
  assign net_b = (addr[31:24] == NET_PRIV_B_HI) && (addr[23:20] == NET_PRIV_B_LO);
  assign net_c = (addr[31:24] == NET_PRIV_C_HI) && (addr[23:16] == NET_PRIV_C_LO);

  always_comb begin
    result_o.valid_res   = ok_i;
    result_o.address     = addr;
    result_o.is_loopback = ok_i && (addr[31:24] == NET_LOOPBACK);
    result_o.is_private  = ok_i && (net_a || net_b || net_c);
  end

endmodule

// ----- hw/rtl/ipv4p_parser.sv -----
module ipv4p_parser import ipv4p_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic             last_char_i,
  output ipv4p_result_t    result_o
);

  ipv4p_state_t     state_q;
  ipv4p_state_t     state_d;
  ipv4p_state_t     nxt;
  logic [3:0]       digit;
  logic [OctetW:0]  times_ten;
  logic             ok;
  logic [AddrW-1:0] addr;

  assign digit     = char_code_i[3:0];
  // value * 10 + digit; at most 255 when the range check has passed.
  assign times_ten = {state_q.octet_value, 1'b0} + {state_q.octet_value[OctetW-3:0], 3'b000}
                   + {5'd0, digit};

  always_comb begin
    nxt = state_q;
    if (!state_q.error_seen) begin
      if (char_code_i inside {[CHAR_ZERO:CHAR_NINE]}) begin
        case (state_q.digit_count)
          2'd0: begin
            nxt.octet_value = {4'd0, digit};
            nxt.digit_count = 2'd1;
          end
          2'd1: begin
            if (state_q.octet_value == '0) begin
              nxt.error_seen = 1'b1;
            end else begin
              nxt.octet_value = times_ten[OctetW-1:0];
              nxt.digit_count = 2'd2;
            end
          end
          2'd2: begin
            if ((state_q.octet_value > OCTET_TENS_MAX) ||
                ((state_q.octet_value == OCTET_TENS_MAX) && (char_code_i > CHAR_FIVE))) begin
              nxt.error_seen = 1'b1;
            end else begin
              nxt.octet_value = times_ten[OctetW-1:0];
              nxt.digit_count = 2'd3;
            end
          end
          default: begin
            nxt.error_seen = 1'b1;
          end
        endcase
      end else if (char_code_i == CHAR_DOT) begin
        if ((state_q.digit_count == '0) || (state_q.octet_index == LAST_OCTET_IDX)) begin
          nxt.error_seen = 1'b1;
        end else begin
          nxt.upper_octets = {state_q.upper_octets[UpperW-OctetW-1:0], state_q.octet_value};
          nxt.octet_value  = '0;
          nxt.digit_count  = '0;
          nxt.octet_index  = state_q.octet_index + 2'd1;
        end
      end else begin
        nxt.error_seen = 1'b1;
      end
    end
  end

  assign ok   = !nxt.error_seen && (nxt.octet_index == LAST_OCTET_IDX) && (nxt.digit_count != '0);
  assign addr = {nxt.upper_octets, nxt.octet_value};

  ipv4p_classify u_classify (
    .ok_i      (ok),
    .address_i (addr),
    .result_o  (result_o)
  );

  // The string ends on the last character and the next one starts fresh.
  always_comb begin
    state_d = state_q;
    if (step_i) begin
      state_d = last_char_i ? STATE_RESET : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
